FILE: rtl/txpwr_pkg.sv
// Package for the transmit power search block
// Holds field widths, mode codes and configuration register indexes
// No dependencies
`timescale 1ns / 1ps
`default_nettype none

package txpwr_pkg;

    localparam int MODE_W   = 3;
    localparam int ENTRY_W  = 4;
    localparam int POWER_W  = 7;
    localparam int COUNT_W  = 8;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam mode_t MODE_OPEN   = 3'd0;
    localparam mode_t MODE_CLOSE  = 3'd1;
    localparam mode_t MODE_TICK   = 3'd2;
    localparam mode_t MODE_REPORT = 3'd3;

    localparam cfg_index_t CFG_PROBES_PER_ROUND = 3'd0;
    localparam cfg_index_t CFG_SUCCESSES_NEEDED = 3'd1;
    localparam cfg_index_t CFG_SAFETY_MARGIN    = 3'd2;
    localparam cfg_index_t CFG_TX_POWER_MAX     = 3'd3;
    localparam cfg_index_t CFG_TX_POWER_MIN     = 3'd4;

    localparam logic [COUNT_W-1:0] RST_PROBES_PER_ROUND = 8'd10;
    localparam logic [COUNT_W-1:0] RST_SUCCESSES_NEEDED = 8'd8;
    localparam logic [POWER_W-1:0] RST_SAFETY_MARGIN    = 7'd2;
    localparam logic [POWER_W-1:0] RST_TX_POWER_MAX     = 7'd31;
    localparam logic [POWER_W-1:0] RST_TX_POWER_MIN     = 7'd0;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [7:0] POWER_INACTIVE = 8'hFF;

endpackage

`default_nettype wire

FILE: rtl/tx_power_binary_search.sv
// Transmit power search: per-entry binary search over a power level ladder
// An accepted beat is held in the input register, then moves to the result register.
// Throughput: one beat per cycle unless m_tready holds off; the entry
// read-modify-write sits between the input register and the result register,
// so back-to-back beats to the same entry need no forwarding.
// Reset clears configuration to defaults and all entries to inactive.
// Depends on txpwr_pkg
`timescale 1ns / 1ps
`default_nettype none

module tx_power_binary_search #(
    parameter int LEVELS  = 8,
    parameter int ENTRIES = 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // mode[2:0], entry[6:3], tx_power[13:7], acked[14]
    input  wire  [txpwr_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // send_probe[0], probe_power[7:1], entry_power[15:8], round_done[16],
    // search_done[17]
    output logic [txpwr_pkg::M_DATA_W-1:0]    m_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    input  wire                               cfg_we,
    input  wire  [txpwr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [txpwr_pkg::CFG_W-1:0]       cfg_data
);
    import txpwr_pkg::*;

    localparam int DEPTH   = (ENTRIES < (1 << ENTRY_W)) ? ENTRIES : (1 << ENTRY_W);
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LW      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SH      = 20;
    localparam int RECIP   = ((1 << SH) + LEVELS - 1) / LEVELS;
    localparam int THRESH  = ((LEVELS / 2 + 1) * (1 << SH) + LEVELS - 1) / LEVELS;
    localparam int SCALE_W = SH + 1;
    localparam int PROD_W  = SCALE_W + POWER_W;

    // configuration
    logic [COUNT_W-1:0] probes_per_round_reg;
    logic [COUNT_W-1:0] successes_needed_reg;
    logic [POWER_W-1:0] safety_margin_reg;
    logic [POWER_W-1:0] tx_power_max_reg;
    logic [POWER_W-1:0] tx_power_min_reg;

    // entry table
    logic               entry_active_reg   [DEPTH];
    logic               entry_finished_reg [DEPTH];
    logic [POWER_W-1:0] chosen_power_reg   [DEPTH];
    logic [COUNT_W-1:0] probes_sent_reg    [DEPTH];
    logic [COUNT_W-1:0] acks_received_reg  [DEPTH];
    logic [LW-1:0]      range_low_reg      [DEPTH];
    logic [LW-1:0]      range_high_reg     [DEPTH];

    // input register
    logic               in_valid_reg;
    mode_t              in_mode_reg;
    logic [ENTRY_W-1:0] in_entry_reg;
    logic [POWER_W-1:0] in_tx_power_reg;
    logic               in_acked_reg;

    // result register
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    logic advance;
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // level ladder scale factors, (i+1) * ceil(2^SH / LEVELS)
    logic [SCALE_W-1:0] scale_tbl [LEVELS];
    for (genvar g = 0; g < LEVELS; g++) begin : g_scale
        assign scale_tbl[g] = SCALE_W'((g + 1) * RECIP);
    end

    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic               act, fin;
    logic [POWER_W-1:0] cp;
    logic [COUNT_W-1:0] ps, ar;
    logic [LW-1:0]      lo, hi, mid;
    logic [POWER_W-1:0] span;
    logic [PROD_W-1:0]  prod;
    logic [POWER_W-1:0] mid_power;
    logic [COUNT_W:0]   found_power;
    logic [POWER_W-1:0] capped_power;
    logic signed [COUNT_W+1:0] lost_lhs, lost_rhs;

    logic               act_next, fin_next;
    logic [POWER_W-1:0] cp_next;
    logic [COUNT_W-1:0] ps_next, ar_next;
    logic [LW-1:0]      lo_next, hi_next;
    logic               send, rdone;
    logic [POWER_W-1:0] ppow;
    logic [7:0]         epow;
    logic               sdone;

    assign idx      = in_entry_reg[IDX_W-1:0];
    assign in_range = (32'(in_entry_reg) < ENTRIES);
    assign act      = entry_active_reg[idx];
    assign fin      = entry_finished_reg[idx];
    assign cp       = chosen_power_reg[idx];
    assign ps       = probes_sent_reg[idx];
    assign ar       = acks_received_reg[idx];
    assign lo       = range_low_reg[idx];
    assign hi       = range_high_reg[idx];

    always_comb begin
        logic [LW-1:0] m_raw;
        m_raw = (hi >= lo) ? LW'(lo + ((hi - lo) >> 1)) : lo;
        mid   = (32'(m_raw) >= LEVELS - 1) ? LW'(LEVELS - 1) : m_raw;
    end

    // ladder level by reciprocal multiply; fraction decides round-half-down
    assign span = (tx_power_max_reg >= tx_power_min_reg) ?
                  POWER_W'(tx_power_max_reg - tx_power_min_reg) : '0;
    assign prod = PROD_W'(span) * PROD_W'(scale_tbl[mid]);

    always_comb begin
        logic [POWER_W-1:0] q;
        logic               up;
        q  = POWER_W'(prod[PROD_W-1:SH]);
        up = ({1'b0, prod[SH-1:0]} >= (SH + 1)'(THRESH));
        if (32'(mid) >= LEVELS - 1) begin
            mid_power = tx_power_max_reg;
        end else begin
            mid_power = POWER_W'(q + POWER_W'(up));
        end
    end

    assign found_power  = (COUNT_W + 1)'(safety_margin_reg) + (COUNT_W + 1)'(mid_power);
    assign capped_power = (found_power > (COUNT_W + 1)'(tx_power_max_reg)) ?
                          tx_power_max_reg : POWER_W'(found_power);

    assign lost_lhs = $signed({2'b00, ps}) - $signed({2'b00, ar});
    assign lost_rhs = $signed({2'b00, probes_per_round_reg})
                    - $signed({2'b00, successes_needed_reg});

    always_comb begin
        act_next = act;
        fin_next = fin;
        cp_next  = cp;
        ps_next  = ps;
        ar_next  = ar;
        lo_next  = lo;
        hi_next  = hi;
        send     = 1'b0;
        ppow     = '0;
        rdone    = 1'b0;
        if (in_range) begin
            case (in_mode_reg)
                MODE_OPEN: begin
                    act_next = 1'b1;
                    fin_next = 1'b0;
                    cp_next  = tx_power_max_reg;
                    ps_next  = '0;
                    ar_next  = '0;
                    lo_next  = '0;
                    hi_next  = LW'(LEVELS - 1);
                end
                MODE_CLOSE: begin
                    act_next = 1'b0;
                    fin_next = 1'b0;
                end
                MODE_TICK: begin
                    if (act && !fin) begin
                        if (ps < probes_per_round_reg) begin
                            if (!(ar >= successes_needed_reg) && !(lost_lhs > lost_rhs)) begin
                                send = 1'b1;
                                ppow = mid_power;
                            end
                            ps_next = COUNT_W'(ps + 1'b1);
                        end else begin
                            rdone = 1'b1;
                            if (ar >= successes_needed_reg) begin
                                hi_next = mid;
                                cp_next = capped_power;
                            end else begin
                                lo_next = mid;
                            end
                            if ((LW + 1)'(hi_next) < (LW + 1)'(lo_next) + (LW + 1)'(2)) begin
                                fin_next = 1'b1;
                            end else begin
                                ps_next = '0;
                                ar_next = '0;
                            end
                        end
                    end
                end
                MODE_REPORT: begin
                    if (act && in_acked_reg && (in_tx_power_reg == mid_power)
                        && (ar != COUNT_MAX)) begin
                        ar_next = COUNT_W'(ar + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
        if (in_range && act_next) begin
            epow  = {1'b0, cp_next};
            sdone = fin_next;
        end else begin
            epow  = POWER_INACTIVE;
            sdone = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probes_per_round_reg <= RST_PROBES_PER_ROUND;
            successes_needed_reg <= RST_SUCCESSES_NEEDED;
            safety_margin_reg    <= RST_SAFETY_MARGIN;
            tx_power_max_reg     <= RST_TX_POWER_MAX;
            tx_power_min_reg     <= RST_TX_POWER_MIN;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_PROBES_PER_ROUND: probes_per_round_reg <= cfg_data;
                CFG_SUCCESSES_NEEDED: successes_needed_reg <= cfg_data;
                CFG_SAFETY_MARGIN:    safety_margin_reg    <= cfg_data[POWER_W-1:0];
                CFG_TX_POWER_MAX:     tx_power_max_reg     <= cfg_data[POWER_W-1:0];
                CFG_TX_POWER_MIN:     tx_power_min_reg     <= cfg_data[POWER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DEPTH; i++) begin
                entry_active_reg[i]   <= 1'b0;
                entry_finished_reg[i] <= 1'b0;
            end
        end else if (advance && in_range) begin
            entry_active_reg[idx]   <= act_next;
            entry_finished_reg[idx] <= fin_next;
        end
    end

    // payload part of the table, no reset
    always_ff @(posedge aclk) begin
        if (advance && in_range) begin
            chosen_power_reg[idx]  <= cp_next;
            probes_sent_reg[idx]   <= ps_next;
            acks_received_reg[idx] <= ar_next;
            range_low_reg[idx]     <= lo_next;
            range_high_reg[idx]    <= hi_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg     <= s_tdata[2:0];
            in_entry_reg    <= s_tdata[6:3];
            in_tx_power_reg <= s_tdata[13:7];
            in_acked_reg    <= s_tdata[14];
        end
        if (advance) begin
            out_data_reg <= {6'b0, sdone, rdone, epow, ppow, send};
        end
    end

endmodule

`default_nettype wire

FILE: dv/tx_power_binary_search_tb.sv
// Self-checking bench for the transmit power search block: directed table, then
// random and ack saturation phases under several register settings, checked by a predictor
// Depends on txpwr_pkg and tx_power_binary_search
`timescale 1ns / 1ps

module tx_power_binary_search_tb;

    import txpwr_pkg::*;

    localparam int LADDER_LEVELS  = 8;
    localparam int TABLE_ENTRIES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 40;
    localparam int SAT_REPORTS    = 258;
    localparam int N_DIRECTED     = 19;
    localparam int N_PHASES       = 8;
    localparam int SAT_PHASE      = 4;

    localparam mode_t MODE_QUERY    = 3'd4;
    localparam mode_t MODE_SPARE_LO = 3'd5;
    localparam mode_t MODE_SPARE_HI = 3'd7;

    // fields from the lowest bit up: mode, entry, tx_power, acked
    typedef struct packed {
        logic         acked;
        logic [6:0]   tx_power;
        logic [3:0]   entry;
        mode_t        mode;
    } item_t;

    // fields from the lowest bit up: send_probe, probe_power, entry_power,
    // round_done, search_done
    typedef struct packed {
        logic         search_done;
        logic         round_done;
        logic [7:0]   entry_power;
        logic [6:0]   probe_power;
        logic         send_probe;
    } result_t;

    typedef struct packed {
        mode_t        mode;
        logic [3:0]   entry;
        logic [6:0]   txp;
        logic         acked;
        logic         fixed;
        result_t      res;
    } dir_row_t;

    typedef struct packed {
        logic [7:0]   ppr;
        logic [7:0]   need;
        logic [6:0]   margin;
        logic [6:0]   pmax;
        logic [6:0]   pmin;
        logic [9:0]   n_beats;
    } phase_cfg_t;

    localparam result_t RES_OFF   = '{1'b0, 1'b0, POWER_INACTIVE, 7'd0, 1'b0};
    localparam result_t RES_TOP   = '{1'b0, 1'b0, 8'd31, 7'd0, 1'b0};
    localparam result_t RES_PROBE = '{1'b0, 1'b0, 8'd31, 7'd15, 1'b1};

    dir_row_t dir_rows [N_DIRECTED] = '{
        '{MODE_QUERY,    4'd0,  7'd0,   1'b0, 1'b1, RES_OFF},
        '{MODE_REPORT,   4'd3,  7'd127, 1'b1, 1'b1, RES_OFF},
        '{MODE_TICK,     4'd5,  7'd0,   1'b0, 1'b1, RES_OFF},
        '{MODE_CLOSE,    4'd6,  7'd0,   1'b0, 1'b1, RES_OFF},
        '{MODE_OPEN,     4'd0,  7'd0,   1'b0, 1'b1, RES_TOP},
        '{MODE_QUERY,    4'd0,  7'd0,   1'b0, 1'b1, RES_TOP},
        '{MODE_SPARE_HI, 4'd0,  7'd127, 1'b1, 1'b1, RES_TOP},
        '{MODE_TICK,     4'd0,  7'd0,   1'b0, 1'b1, RES_PROBE},
        '{MODE_REPORT,   4'd0,  7'd15,  1'b1, 1'b0, RES_OFF},
        '{MODE_REPORT,   4'd0,  7'd14,  1'b1, 1'b0, RES_OFF},
        '{MODE_REPORT,   4'd0,  7'd15,  1'b0, 1'b0, RES_OFF},
        '{MODE_TICK,     4'd0,  7'd0,   1'b0, 1'b0, RES_OFF},
        '{MODE_OPEN,     4'd0,  7'd0,   1'b0, 1'b1, RES_TOP},
        '{MODE_OPEN,     4'd15, 7'd0,   1'b0, 1'b1, RES_TOP},
        '{MODE_CLOSE,    4'd15, 7'd0,   1'b0, 1'b1, RES_OFF},
        '{MODE_TICK,     4'd15, 7'd0,   1'b0, 1'b1, RES_OFF},
        '{MODE_REPORT,   4'd15, 7'd15,  1'b1, 1'b1, RES_OFF},
        '{MODE_SPARE_LO, 4'd9,  7'd0,   1'b0, 1'b1, RES_OFF},
        '{MODE_CLOSE,    4'd0,  7'd0,   1'b0, 1'b1, RES_OFF}
    };

    phase_cfg_t phase_plan [N_PHASES] = '{
        '{8'd10,  8'd8,   7'd2,   7'd31,  7'd0,   10'd60},
        '{8'd3,   8'd2,   7'd0,   7'd127, 7'd0,   10'd60},
        '{8'd0,   8'd0,   7'd127, 7'd127, 7'd127, 10'd40},
        '{8'd2,   8'd5,   7'd5,   7'd10,  7'd100, 10'd50},
        '{8'd1,   8'd1,   7'd3,   7'd31,  7'd0,   10'd0},
        '{8'd255, 8'd255, 7'd0,   7'd0,   7'd127, 10'd30},
        '{8'd4,   8'd0,   7'd1,   7'd90,  7'd7,   10'd60},
        '{8'd6,   8'd4,   7'd10,  7'd100, 7'd20,  10'd70}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data  = '0;

    // predictor copy of registers and entry table
    logic [7:0] cfg_ppr    = RST_PROBES_PER_ROUND;
    logic [7:0] cfg_need   = RST_SUCCESSES_NEEDED;
    logic [6:0] cfg_margin = RST_SAFETY_MARGIN;
    logic [6:0] cfg_max    = RST_TX_POWER_MAX;
    logic [6:0] cfg_min    = RST_TX_POWER_MIN;

    bit         ent_active   [TABLE_ENTRIES];
    bit         ent_finished [TABLE_ENTRIES];
    logic [6:0] ent_power    [TABLE_ENTRIES];
    int         ent_probes   [TABLE_ENTRIES];
    int         ent_acks     [TABLE_ENTRIES];
    int         ent_lo       [TABLE_ENTRIES];
    int         ent_hi       [TABLE_ENTRIES];
    int         ack_floor    [TABLE_ENTRIES];

    result_t    pending_results [$];
    result_t    got_beat;
    result_t    want_beat;
    int         bad_beats    = 0;
    int         quiet_cycles = 0;
    int         tx_idle_pct  = 0;
    int         rx_idle_pct  = 0;
    bit         hold_req     = 1'b0;
    bit         hold_seen    = 1'b0;
    int         hold_left    = 0;

    tx_power_binary_search #(
        .LEVELS  (LADDER_LEVELS),
        .ENTRIES (TABLE_ENTRIES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [6:0] ladder_power(int idx);
        int span;
        int num;
        int q;
        if (idx >= LADDER_LEVELS - 1) return cfg_max;
        span = (cfg_max >= cfg_min) ? int'(cfg_max) - int'(cfg_min) : 0;
        num  = span * (idx + 1);
        q    = num / LADDER_LEVELS;
        // exact half rounds down
        if (2 * (num % LADDER_LEVELS) > LADDER_LEVELS) q++;
        return q[6:0];
    endfunction

    function automatic int search_mid(int e);
        int m;
        m = (ent_hi[e] >= ent_lo[e]) ? ent_lo[e] + (ent_hi[e] - ent_lo[e]) / 2
                                     : ent_lo[e];
        if (m >= LADDER_LEVELS) m = LADDER_LEVELS - 1;
        return m;
    endfunction

    function automatic result_t step_power_search(item_t it);
        result_t res;
        int e;
        int m;
        int p;
        int total;
        int need;
        res   = '0;
        e     = it.entry;
        total = cfg_ppr;
        need  = cfg_need;
        case (it.mode)
            MODE_OPEN: begin
                ent_active[e]   = 1'b1;
                ent_finished[e] = 1'b0;
                ent_power[e]    = cfg_max;
                ent_probes[e]   = 0;
                ent_acks[e]     = 0;
                ent_lo[e]       = 0;
                ent_hi[e]       = LADDER_LEVELS - 1;
            end
            MODE_CLOSE: begin
                ent_active[e]   = 1'b0;
                ent_finished[e] = 1'b0;
            end
            MODE_TICK: begin
                if (ent_active[e] && !ent_finished[e]) begin
                    if (ent_probes[e] < total) begin
                        // no probe once the round is won or lost
                        if (ent_acks[e] < need
                                && ent_probes[e] - ent_acks[e] <= total - need) begin
                            res.send_probe  = 1'b1;
                            res.probe_power = ladder_power(search_mid(e));
                        end
                        ent_probes[e]++;
                    end else begin
                        m = search_mid(e);
                        res.round_done = 1'b1;
                        if (ent_acks[e] >= need) begin
                            ent_hi[e] = m;
                            p = int'(cfg_margin) + int'(ladder_power(m));
                            if (p > cfg_max) p = cfg_max;
                            ent_power[e] = p[6:0];
                        end else begin
                            ent_lo[e] = m;
                        end
                        if (ent_hi[e] - ent_lo[e] < 2) begin
                            ent_finished[e] = 1'b1;
                        end else begin
                            ent_probes[e] = 0;
                            ent_acks[e]   = 0;
                        end
                    end
                end
            end
            MODE_REPORT: begin
                if (ent_active[e] && it.acked && it.tx_power == ladder_power(search_mid(e))
                        && ent_acks[e] < COUNT_MAX)
                    ent_acks[e]++;
            end
            default: ;
        endcase
        res.entry_power = ent_active[e] ? {1'b0, ent_power[e]} : POWER_INACTIVE;
        res.search_done = ent_active[e] && ent_finished[e];
        return res;
    endfunction

    // mostly well-formed searches on a few entries, acks follow a hidden power floor
    function automatic item_t pick_beat(int base);
        item_t it;
        int e;
        int mid;
        int roll;
        it.mode     = mode_t'($urandom_range(0, 7));
        it.entry    = 4'($urandom);
        it.tx_power = 7'($urandom);
        it.acked    = 1'($urandom);
        if ($urandom_range(0, 99) < 8) return it;
        e        = (base + $urandom_range(0, 5)) % TABLE_ENTRIES;
        it.entry = e[3:0];
        mid      = search_mid(e);
        roll     = $urandom_range(0, 99);
        if (!ent_active[e]) begin
            if (roll < 85) it.mode = MODE_OPEN;
        end else if (ent_finished[e]) begin
            if (roll < 35) it.mode = MODE_OPEN;
            else if (roll < 55) it.mode = MODE_CLOSE;
            else if (roll < 70) it.mode = MODE_QUERY;
            else if (roll < 85) it.mode = MODE_TICK;
            else begin
                it.mode     = MODE_REPORT;
                it.tx_power = ladder_power(mid);
            end
        end else if (roll < 55) begin
            it.mode = MODE_TICK;
        end else if (roll < 85) begin
            it.mode     = MODE_REPORT;
            it.tx_power = ladder_power(mid);
            it.acked    = (mid >= ack_floor[e]) ? ($urandom_range(0, 99) < 92)
                                                : ($urandom_range(0, 99) < 8);
        end else if (roll < 90) begin
            it.mode = MODE_REPORT;
        end else if (roll < 94) begin
            it.mode = MODE_QUERY;
        end else if (roll < 97) begin
            it.mode = MODE_CLOSE;
        end else begin
            it.mode = MODE_OPEN;
        end
        if (it.mode == MODE_OPEN) ack_floor[e] = $urandom_range(0, LADDER_LEVELS);
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_beat(item_t it, logic fixed, result_t fixed_res);
        result_t res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= S_DATA_W'(it);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        res = step_power_search(it);
        pending_results.push_back(fixed ? fixed_res : res);
        @(negedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_PROBES_PER_ROUND: cfg_ppr    = value;
            CFG_SUCCESSES_NEEDED: cfg_need   = value;
            CFG_SAFETY_MARGIN:    cfg_margin = value[6:0];
            CFG_TX_POWER_MAX:     cfg_max    = value[6:0];
            CFG_TX_POWER_MIN:     cfg_min    = value[6:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    // receiver backpressure, with a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_beat = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (pending_results.size() == 0) begin
                bad_beats++;
                if (bad_beats <= 10) $display("unexpected result beat %h", m_tdata);
            end else begin
                want_beat = pending_results.pop_front();
                if (got_beat.send_probe  !== want_beat.send_probe  ||
                    got_beat.probe_power !== want_beat.probe_power ||
                    got_beat.entry_power !== want_beat.entry_power ||
                    got_beat.round_done  !== want_beat.round_done  ||
                    got_beat.search_done !== want_beat.search_done) begin
                    bad_beats++;
                    if (bad_beats <= 10)
                        $display({"mismatch: exp probe=%0d ppow=%0d epow=%0d rnd=%0d ",
                                  "srch=%0d, got probe=%0d ppow=%0d epow=%0d rnd=%0d ",
                                  "srch=%0d"},
                                 want_beat.send_probe, want_beat.probe_power,
                                 $signed(want_beat.entry_power), want_beat.round_done,
                                 want_beat.search_done, got_beat.send_probe,
                                 got_beat.probe_power, $signed(got_beat.entry_power),
                                 got_beat.round_done, got_beat.search_done);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        item_t it;
        int base;
        int e;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        tx_idle_pct = 22;
        rx_idle_pct = 65;
        for (int r = 0; r < N_DIRECTED; r++) begin
            it.mode     = dir_rows[r].mode;
            it.entry    = dir_rows[r].entry;
            it.tx_power = dir_rows[r].txp;
            it.acked    = dir_rows[r].acked;
            send_beat(it, dir_rows[r].fixed, dir_rows[r].res);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            // registers change only with the block drained
            s_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge aclk);
            repeat (2) @(negedge aclk);
            write_reg(CFG_PROBES_PER_ROUND, phase_plan[p].ppr);
            write_reg(CFG_SUCCESSES_NEEDED, phase_plan[p].need);
            write_reg(CFG_SAFETY_MARGIN,    {1'b0, phase_plan[p].margin});
            write_reg(CFG_TX_POWER_MAX,     {1'b0, phase_plan[p].pmax});
            write_reg(CFG_TX_POWER_MIN,     {1'b0, phase_plan[p].pmin});
            cfg_we <= 1'b0;
            if (p >= 6) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (p >= 3) begin
                tx_idle_pct = 65;
                rx_idle_pct = 22;
            end
            if (p == 1 || p == 6) hold_req = ~hold_req;
            base = $urandom_range(0, TABLE_ENTRIES - 1);
            if (p == SAT_PHASE) begin
                // ack count must stick at its ceiling, so the next tick sends no probe
                e           = base;
                it.entry    = e[3:0];
                it.mode     = MODE_OPEN;
                it.tx_power = 7'($urandom);
                it.acked    = 1'b0;
                send_beat(it, 1'b0, RES_OFF);
                it.mode     = MODE_REPORT;
                it.acked    = 1'b1;
                it.tx_power = ladder_power(search_mid(e));
                for (int k = 0; k < SAT_REPORTS; k++) send_beat(it, 1'b0, RES_OFF);
                it.mode = MODE_TICK;
                send_beat(it, 1'b0, RES_OFF);
                send_beat(it, 1'b0, RES_OFF);
                it.mode = MODE_QUERY;
                send_beat(it, 1'b0, RES_OFF);
            end else begin
                for (int k = 0; k < phase_plan[p].n_beats; k++)
                    send_beat(pick_beat(base), 1'b0, RES_OFF);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (bad_beats == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

FILE: files.f
rtl/txpwr_pkg.sv
rtl/tx_power_binary_search.sv
dv/tx_power_binary_search_tb.sv
